// ===== rtl/core/sacm_pkg.sv =====
// Shared types, widths and codes for the serial converter conversion master.
package sacm_pkg;

  localparam int WAIT_W   = 16;
  localparam int FRAME_W  = 20;
  localparam int SEL_W    = 4;
  localparam int SAMPLE_W = 10;
  localparam int BIT_W    = 4;
  localparam int ERR_W    = 3;
  localparam int IDX_W    = 3;
  localparam int CFG_W    = 20;

  typedef logic [WAIT_W-1:0]   wait_t;
  typedef logic [FRAME_W-1:0]  frame_t;
  typedef logic [SEL_W-1:0]    sel_t;
  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [BIT_W-1:0]    bit_cnt_t;

  // Default fixed waits of the enable, first bit and disable steps.
  localparam int unsigned ENABLE_WAIT_DEFAULT    = 10;
  localparam int unsigned FIRST_BIT_WAIT_DEFAULT = 13;
  localparam int unsigned DISABLE_WAIT_DEFAULT   = 10;

  localparam frame_t FRAME_MAX = '1;

  // Bit counts of the command, sample and echo parts of a frame.
  localparam bit_cnt_t CMD_BITS    = bit_cnt_t'(4);
  localparam bit_cnt_t SAMPLE_BITS = bit_cnt_t'(10);
  localparam bit_cnt_t ECHO_BITS   = bit_cnt_t'(9);

  // Register reset values.
  localparam wait_t  CS_HIGH_RESET     = wait_t'(100);
  localparam wait_t  CS_SETUP_RESET    = wait_t'(10);
  localparam wait_t  DATA_HOLD_RESET   = wait_t'(5);
  localparam wait_t  DATA_SETUP_RESET  = wait_t'(5);
  localparam wait_t  CLOCK_HIGH_RESET  = wait_t'(13);
  localparam wait_t  CLOCK_LOW_RESET   = wait_t'(13);
  localparam frame_t FRAME_LIMIT_RESET = frame_t'(100000);

  typedef enum logic [IDX_W-1:0] {
    REG_MONITOR_ENABLE,
    REG_CS_HIGH,
    REG_CS_SETUP,
    REG_DATA_HOLD,
    REG_DATA_SETUP,
    REG_CLOCK_HIGH,
    REG_CLOCK_LOW,
    REG_FRAME_LIMIT
  } reg_index_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE,
    ERR_START_LOW,
    ERR_NULL_HIGH,
    ERR_ECHO,
    ERR_TIMEOUT,
    ERR_END_LOW
  } error_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CSH,
    PH_SUCS,
    PH_SEND_HD,
    PH_SEND_SU,
    PH_SMP_HD,
    PH_SMP_SU,
    PH_SMP_HD2,
    PH_EN,
    PH_RX_HI,
    PH_RX_LO,
    PH_EC_HI,
    PH_EC_LO,
    PH_DIS
  } phase_t;

  typedef struct packed {
    logic   monitor_enable;
    wait_t  cs_high_cycles;
    wait_t  cs_setup_cycles;
    wait_t  data_hold_cycles;
    wait_t  data_setup_cycles;
    wait_t  clock_high_cycles;
    wait_t  clock_low_cycles;
    frame_t frame_limit_cycles;
  } cfg_t;

  typedef struct packed {
    logic kind;
    sel_t channel_select;
    logic dout_level;
  } item_t;

  typedef struct packed {
    logic             cs_n;
    logic             sclk;
    logic             mosi;
    logic             busy_res;
    logic             done_res;
    sample_t          sample;
    logic [ERR_W-1:0] error;
  } result_t;

endpackage

// ===== rtl/core/sacm_cmd_if.sv =====
// Input channel: one tick item with its start request, select and sampled data level.
interface sacm_cmd_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [sacm_pkg::SEL_W-1:0] channel_select;
  logic                     dout_level;

  modport source (output valid, output kind, output channel_select, output dout_level,
                  input ready);
  modport sink (input valid, input kind, input channel_select, input dout_level,
                output ready);
endinterface

// ===== rtl/core/sacm_res_if.sv =====
// Result channel: pin levels and frame status after one tick.
interface sacm_res_if;
  logic                          valid;
  logic                          ready;
  logic                          cs_n;
  logic                          sclk;
  logic                          mosi;
  logic                          busy_res;
  logic                          done_res;
  logic [sacm_pkg::SAMPLE_W-1:0] sample;
  logic [sacm_pkg::ERR_W-1:0]    error;

  modport source (output valid, output cs_n, output sclk, output mosi, output busy_res,
                  output done_res, output sample, output error, input ready);
  modport sink (input valid, input cs_n, input sclk, input mosi, input busy_res,
                input done_res, input sample, input error, output ready);
endinterface

// ===== rtl/core/spi_adc_conversion_master.sv =====
// Top level of the serial conversion master for a 10-bit converter.
// Each transfer on cmd is one clock tick of the pin sequencer and yields exactly one result
// transfer on res carrying the pin levels after that tick and the frame status. A tick is held in
// the input register, then goes through the sequencer logic into the result register. One tick is
// accepted every cycle as long as res is taken; the only limit on throughput is the result register,
// which frees when the sink takes it.
// Register writes on the wr_* port take effect on the next cycle and belong in idle periods.
module spi_adc_conversion_master #(
  parameter int unsigned ENABLE_WAIT_CYCLES    = sacm_pkg::ENABLE_WAIT_DEFAULT,
  parameter int unsigned FIRST_BIT_WAIT_CYCLES = sacm_pkg::FIRST_BIT_WAIT_DEFAULT,
  parameter int unsigned DISABLE_WAIT_CYCLES   = sacm_pkg::DISABLE_WAIT_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  sacm_cmd_if.sink                   cmd,
  sacm_res_if.source                 res,
  input  logic                       wr_en,
  input  logic [sacm_pkg::IDX_W-1:0] wr_index,
  input  logic [sacm_pkg::CFG_W-1:0] wr_data
);

  sacm_pkg::cfg_t    cfg;
  sacm_pkg::item_t   item;
  sacm_pkg::result_t result;
  logic              item_valid;
  logic              space;
  logic              advance;

  assign advance = item_valid && space;

  sacm_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  sacm_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .advance (advance),
    .valid   (item_valid),
    .item    (item)
  );

  sacm_seq #(
    .ENABLE_WAIT_CYCLES    (ENABLE_WAIT_CYCLES),
    .FIRST_BIT_WAIT_CYCLES (FIRST_BIT_WAIT_CYCLES),
    .DISABLE_WAIT_CYCLES   (DISABLE_WAIT_CYCLES)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  sacm_out_reg u_out_reg (
    .clk   (clk),
    .rst   (rst),
    .load  (advance),
    .data  (result),
    .space (space),
    .res   (res)
  );

endmodule

// ===== rtl/core/sacm_cfg_regs.sv =====
// Configuration register bank written through the plain write port.
module sacm_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [sacm_pkg::IDX_W-1:0]   wr_index,
  input  logic [sacm_pkg::CFG_W-1:0]   wr_data,
  output sacm_pkg::cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.monitor_enable     <= 1'b0;
      cfg.cs_high_cycles     <= sacm_pkg::CS_HIGH_RESET;
      cfg.cs_setup_cycles    <= sacm_pkg::CS_SETUP_RESET;
      cfg.data_hold_cycles   <= sacm_pkg::DATA_HOLD_RESET;
      cfg.data_setup_cycles  <= sacm_pkg::DATA_SETUP_RESET;
      cfg.clock_high_cycles  <= sacm_pkg::CLOCK_HIGH_RESET;
      cfg.clock_low_cycles   <= sacm_pkg::CLOCK_LOW_RESET;
      cfg.frame_limit_cycles <= sacm_pkg::FRAME_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (sacm_pkg::reg_index_t'(wr_index))
        sacm_pkg::REG_MONITOR_ENABLE: cfg.monitor_enable    <= wr_data[0];
        sacm_pkg::REG_CS_HIGH:       cfg.cs_high_cycles    <= wr_data[sacm_pkg::WAIT_W-1:0];
        sacm_pkg::REG_CS_SETUP:      cfg.cs_setup_cycles   <= wr_data[sacm_pkg::WAIT_W-1:0];
        sacm_pkg::REG_DATA_HOLD:     cfg.data_hold_cycles  <= wr_data[sacm_pkg::WAIT_W-1:0];
        sacm_pkg::REG_DATA_SETUP:    cfg.data_setup_cycles <= wr_data[sacm_pkg::WAIT_W-1:0];
        sacm_pkg::REG_CLOCK_HIGH:    cfg.clock_high_cycles <= wr_data[sacm_pkg::WAIT_W-1:0];
        sacm_pkg::REG_CLOCK_LOW:     cfg.clock_low_cycles  <= wr_data[sacm_pkg::WAIT_W-1:0];
        sacm_pkg::REG_FRAME_LIMIT:   cfg.frame_limit_cycles <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/sacm_in_reg.sv =====
// Input register stage holding one accepted tick item.
module sacm_in_reg (
  input  logic              clk,
  input  logic              rst,
  sacm_cmd_if.sink          cmd,
  input  logic              advance,
  output logic              valid,
  output sacm_pkg::item_t   item
);

  logic take;

  assign cmd.ready = !valid || advance;
  assign take      = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.kind           <= cmd.kind;
      item.channel_select <= cmd.channel_select;
      item.dout_level     <= cmd.dout_level;
    end
  end

endmodule

// ===== rtl/core/sacm_seq.sv =====
// Frame sequencer: phase state, wait counting, shift registers and pin levels.
module sacm_seq #(
  parameter int unsigned ENABLE_WAIT_CYCLES    = sacm_pkg::ENABLE_WAIT_DEFAULT,
  parameter int unsigned FIRST_BIT_WAIT_CYCLES = sacm_pkg::FIRST_BIT_WAIT_DEFAULT,
  parameter int unsigned DISABLE_WAIT_CYCLES   = sacm_pkg::DISABLE_WAIT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  sacm_pkg::item_t   item,
  input  sacm_pkg::cfg_t    cfg,
  output sacm_pkg::result_t result
);

  localparam sacm_pkg::wait_t ENABLE_WAIT    = sacm_pkg::wait_t'(ENABLE_WAIT_CYCLES);
  localparam sacm_pkg::wait_t FIRST_BIT_WAIT = sacm_pkg::wait_t'(FIRST_BIT_WAIT_CYCLES);
  localparam sacm_pkg::wait_t DISABLE_WAIT   = sacm_pkg::wait_t'(DISABLE_WAIT_CYCLES);

  sacm_pkg::phase_t   phase, phase_next;
  sacm_pkg::wait_t    wait_count, wait_count_next, wait_limit;
  sacm_pkg::bit_cnt_t bit_count, bit_count_next, bit_inc;
  sacm_pkg::sel_t     command_shift, command_shift_next;
  sacm_pkg::sample_t  sample_shift, sample_shift_next, sample_in;
  sacm_pkg::sample_t  echo_shift, echo_shift_next, echo_in;
  sacm_pkg::frame_t   frame_count, frame_count_next, frame_inc;
  logic               cs_n, cs_n_next;
  logic               sclk, sclk_next;
  logic               mosi, mosi_next;

  logic             mon, dout, act;
  logic             err_start, err_null, err_echo, err_timeout, err_end;
  logic             done;
  sacm_pkg::error_t err;
  sacm_pkg::sample_t result_sample;

  assign mon       = cfg.monitor_enable;
  assign dout      = item.dout_level;
  assign bit_inc   = bit_count + sacm_pkg::bit_cnt_t'(1);
  assign sample_in = {sample_shift[sacm_pkg::SAMPLE_W-2:0], dout};
  assign echo_in   = echo_shift >> 1;

  // The frame counter runs from the first clock rise to the end of the frame.
  always_comb begin
    frame_inc = frame_count;
    if (phase != sacm_pkg::PH_IDLE && phase != sacm_pkg::PH_CSH &&
        phase != sacm_pkg::PH_SUCS && frame_count != sacm_pkg::FRAME_MAX) begin
      frame_inc = frame_count + sacm_pkg::frame_t'(1);
    end
  end

  always_comb begin
    unique case (phase)
      sacm_pkg::PH_CSH:     wait_limit = cfg.cs_high_cycles;
      sacm_pkg::PH_SUCS:    wait_limit = cfg.cs_setup_cycles;
      sacm_pkg::PH_SEND_HD,
      sacm_pkg::PH_SMP_HD,
      sacm_pkg::PH_SMP_HD2: wait_limit = cfg.data_hold_cycles;
      sacm_pkg::PH_SEND_SU,
      sacm_pkg::PH_SMP_SU:  wait_limit = cfg.data_setup_cycles;
      sacm_pkg::PH_EN:      wait_limit = ENABLE_WAIT;
      sacm_pkg::PH_RX_HI,
      sacm_pkg::PH_EC_HI:   wait_limit = cfg.clock_high_cycles;
      sacm_pkg::PH_RX_LO:   wait_limit = (bit_count == '0) ? FIRST_BIT_WAIT
                                                           : cfg.clock_low_cycles;
      sacm_pkg::PH_EC_LO:   wait_limit = cfg.clock_low_cycles;
      sacm_pkg::PH_DIS:     wait_limit = DISABLE_WAIT;
      default:              wait_limit = '0;
    endcase
  end

  // A step acts once its wait has fully elapsed.
  assign act = (phase != sacm_pkg::PH_IDLE) && !(wait_count < wait_limit);

  assign err_start   = mon && !dout;
  assign err_null    = mon && dout;
  assign err_echo    = echo_in[0] != dout;
  assign err_timeout = mon && (frame_inc > cfg.frame_limit_cycles);
  assign err_end     = mon && !dout;

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (phase == sacm_pkg::PH_IDLE) begin
      if (item.kind) begin
        phase_next = sacm_pkg::PH_CSH;
      end
    end else if (act) begin
      unique case (phase)
        sacm_pkg::PH_CSH:     phase_next = err_start ? sacm_pkg::PH_IDLE : sacm_pkg::PH_SUCS;
        sacm_pkg::PH_SUCS:    phase_next = sacm_pkg::PH_SEND_HD;
        sacm_pkg::PH_SEND_HD: phase_next = sacm_pkg::PH_SEND_SU;
        sacm_pkg::PH_SEND_SU: phase_next = (bit_inc >= sacm_pkg::CMD_BITS) ?
                                           sacm_pkg::PH_SMP_HD : sacm_pkg::PH_SEND_HD;
        sacm_pkg::PH_SMP_HD:  phase_next = sacm_pkg::PH_SMP_SU;
        sacm_pkg::PH_SMP_SU:  phase_next = sacm_pkg::PH_SMP_HD2;
        sacm_pkg::PH_SMP_HD2: phase_next = sacm_pkg::PH_EN;
        sacm_pkg::PH_EN:      phase_next = err_null ? sacm_pkg::PH_IDLE : sacm_pkg::PH_RX_HI;
        sacm_pkg::PH_RX_HI:   phase_next = sacm_pkg::PH_RX_LO;
        sacm_pkg::PH_RX_LO: begin
          if (bit_inc < sacm_pkg::SAMPLE_BITS) begin
            phase_next = sacm_pkg::PH_RX_HI;
          end else if (mon) begin
            phase_next = sacm_pkg::PH_EC_HI;
          end else begin
            phase_next = sacm_pkg::PH_DIS;
          end
        end
        sacm_pkg::PH_EC_HI:   phase_next = sacm_pkg::PH_EC_LO;
        sacm_pkg::PH_EC_LO: begin
          if (err_echo) begin
            phase_next = sacm_pkg::PH_IDLE;
          end else if (bit_inc >= sacm_pkg::ECHO_BITS) begin
            phase_next = sacm_pkg::PH_DIS;
          end else begin
            phase_next = sacm_pkg::PH_EC_HI;
          end
        end
        default:              phase_next = sacm_pkg::PH_IDLE;
      endcase
    end
  end

  // Datapath, pin levels and the result of this tick.
  always_comb begin
    wait_count_next    = wait_count;
    bit_count_next     = bit_count;
    command_shift_next = command_shift;
    sample_shift_next  = sample_shift;
    echo_shift_next    = echo_shift;
    frame_count_next   = frame_inc;
    cs_n_next          = cs_n;
    sclk_next          = sclk;
    mosi_next          = mosi;
    done               = 1'b0;
    err                = sacm_pkg::ERR_NONE;
    result_sample      = '0;
    if (phase == sacm_pkg::PH_IDLE) begin
      if (item.kind) begin
        command_shift_next = item.channel_select;
        wait_count_next    = '0;
      end
    end else if (!act) begin
      wait_count_next = wait_count + sacm_pkg::wait_t'(1);
    end else begin
      wait_count_next = '0;
      unique case (phase)
        sacm_pkg::PH_CSH: begin
          if (err_start) begin
            done = 1'b1;
            err  = sacm_pkg::ERR_START_LOW;
          end else begin
            cs_n_next = 1'b0;
            mosi_next = 1'b1;
          end
        end
        sacm_pkg::PH_SUCS: begin
          sclk_next        = 1'b1;
          frame_count_next = '0;
          bit_count_next   = '0;
        end
        sacm_pkg::PH_SEND_HD: begin
          sclk_next          = 1'b0;
          mosi_next          = command_shift[sacm_pkg::SEL_W-1];
          command_shift_next = command_shift << 1;
        end
        sacm_pkg::PH_SEND_SU: begin
          sclk_next      = 1'b1;
          bit_count_next = bit_inc;
        end
        sacm_pkg::PH_SMP_HD: begin
          sclk_next = 1'b0;
          mosi_next = 1'b0;
        end
        sacm_pkg::PH_SMP_SU:  sclk_next = 1'b1;
        sacm_pkg::PH_SMP_HD2: sclk_next = 1'b0;
        sacm_pkg::PH_EN: begin
          if (err_null) begin
            done = 1'b1;
            err  = sacm_pkg::ERR_NULL_HIGH;
          end else begin
            sclk_next         = 1'b1;
            bit_count_next    = '0;
            sample_shift_next = '0;
          end
        end
        sacm_pkg::PH_RX_HI:   sclk_next = 1'b0;
        sacm_pkg::PH_RX_LO: begin
          sample_shift_next = sample_in;
          bit_count_next    = bit_inc;
          if (bit_inc < sacm_pkg::SAMPLE_BITS) begin
            sclk_next = 1'b1;
          end else if (mon) begin
            echo_shift_next = sample_in;
            bit_count_next  = '0;
            sclk_next       = 1'b1;
          end else begin
            cs_n_next = 1'b1;
          end
        end
        sacm_pkg::PH_EC_HI:   sclk_next = 1'b0;
        sacm_pkg::PH_EC_LO: begin
          // The converter echoes the sample from bit 1 upward, lowest bit first, after the last result bit.
          echo_shift_next = echo_in;
          if (err_echo) begin
            done = 1'b1;
            err  = sacm_pkg::ERR_ECHO;
          end else begin
            bit_count_next = bit_inc;
            if (bit_inc >= sacm_pkg::ECHO_BITS) begin
              cs_n_next = 1'b1;
            end else begin
              sclk_next = 1'b1;
            end
          end
        end
        sacm_pkg::PH_DIS: begin
          done = 1'b1;
          if (err_timeout) begin
            err = sacm_pkg::ERR_TIMEOUT;
          end else if (err_end) begin
            err = sacm_pkg::ERR_END_LOW;
          end else begin
            result_sample = sample_shift;
          end
        end
        default: begin
          cs_n_next = 1'b1;
          sclk_next = 1'b0;
          mosi_next = 1'b0;
        end
      endcase
      if (done) begin
        cs_n_next = 1'b1;
        sclk_next = 1'b0;
        mosi_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sacm_pkg::PH_IDLE;
      wait_count    <= '0;
      bit_count     <= '0;
      command_shift <= '0;
      sample_shift  <= '0;
      echo_shift    <= '0;
      frame_count   <= '0;
      cs_n          <= 1'b1;
      sclk          <= 1'b0;
      mosi          <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      wait_count    <= wait_count_next;
      bit_count     <= bit_count_next;
      command_shift <= command_shift_next;
      sample_shift  <= sample_shift_next;
      echo_shift    <= echo_shift_next;
      frame_count   <= frame_count_next;
      cs_n          <= cs_n_next;
      sclk          <= sclk_next;
      mosi          <= mosi_next;
    end
  end

  assign result.cs_n     = cs_n_next;
  assign result.sclk     = sclk_next;
  assign result.mosi     = mosi_next;
  assign result.busy_res = phase_next != sacm_pkg::PH_IDLE;
  assign result.done_res = done;
  assign result.sample   = result_sample;
  assign result.error    = err;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    result.done_res |-> !result.busy_res)
    else $error("frame reported done while still busy");

  a_error_needs_done: assert property (@(posedge clk) disable iff (rst)
    (result.error != sacm_pkg::ERR_NONE) |-> result.done_res)
    else $error("error code outside a finishing tick");

  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    !result.busy_res |-> (result.cs_n && !result.sclk && !result.mosi))
    else $error("pins not at idle levels outside a frame");

  a_tick_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && phase == sacm_pkg::PH_IDLE && !item.kind) |=> phase == sacm_pkg::PH_IDLE)
    else $error("plain tick left the idle phase");

endmodule

// ===== rtl/core/sacm_out_reg.sv =====
// Result register that holds one tick result until the sink takes it.
module sacm_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sacm_pkg::result_t data,
  output logic              space,
  sacm_res_if.source        res
);

  logic              valid;
  sacm_pkg::result_t data_q;

  assign space = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_q <= data;
    end
  end

  assign res.valid    = valid;
  assign res.cs_n     = data_q.cs_n;
  assign res.sclk     = data_q.sclk;
  assign res.mosi     = data_q.mosi;
  assign res.busy_res = data_q.busy_res;
  assign res.done_res = data_q.done_res;
  assign res.sample   = data_q.sample;
  assign res.error    = data_q.error;

endmodule

// ===== sim/spi_adc_conversion_master_checker.sv =====
// Checker that predicts every tick result of the conversion master and compares it on the result channel.
module spi_adc_conversion_master_checker
  import sacm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  sacm_cmd_if                 cmd,
  sacm_res_if                 res,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_index,
  input  logic [CFG_W-1:0]    wr_data,
  output int unsigned         fail_count,
  output int unsigned         pending,
  output logic                frame_busy,
  output phase_t              tick_phase,
  output logic                echo_next
);

  cfg_t     cfg;
  phase_t   ph;
  wait_t    wait_cnt;
  bit_cnt_t bit_cnt;
  sel_t     cmd_bits;
  sample_t  sample_bits;
  sample_t  echo_bits;
  frame_t   frame_cnt;
  logic     pin_cs;
  logic     pin_clk;
  logic     pin_data;

  result_t  tick_results_q[$];
  item_t    in_item;
  result_t  want;

  task automatic reset_sequencer();
    cfg.monitor_enable     = 1'b0;
    cfg.cs_high_cycles     = CS_HIGH_RESET;
    cfg.cs_setup_cycles    = CS_SETUP_RESET;
    cfg.data_hold_cycles   = DATA_HOLD_RESET;
    cfg.data_setup_cycles  = DATA_SETUP_RESET;
    cfg.clock_high_cycles  = CLOCK_HIGH_RESET;
    cfg.clock_low_cycles   = CLOCK_LOW_RESET;
    cfg.frame_limit_cycles = FRAME_LIMIT_RESET;
    ph          = PH_IDLE;
    wait_cnt    = '0;
    bit_cnt     = '0;
    cmd_bits    = '0;
    sample_bits = '0;
    echo_bits   = '0;
    frame_cnt   = '0;
    pin_cs      = 1'b1;
    pin_clk     = 1'b0;
    pin_data    = 1'b0;
  endtask

  function automatic int unsigned phase_wait(phase_t p);
    case (p)
      PH_CSH: return cfg.cs_high_cycles;
      PH_SUCS: return cfg.cs_setup_cycles;
      PH_SEND_HD, PH_SMP_HD, PH_SMP_HD2: return cfg.data_hold_cycles;
      PH_SEND_SU, PH_SMP_SU: return cfg.data_setup_cycles;
      PH_EN: return ENABLE_WAIT_DEFAULT;
      PH_RX_HI, PH_EC_HI: return cfg.clock_high_cycles;
      PH_RX_LO: return (bit_cnt == '0) ? FIRST_BIT_WAIT_DEFAULT : int'(cfg.clock_low_cycles);
      PH_EC_LO: return cfg.clock_low_cycles;
      PH_DIS: return DISABLE_WAIT_DEFAULT;
      default: return 0;
    endcase
  endfunction

  // Each tick starts a frame from idle if it asks for one, counts the wait of the current step or performs its action.
  task automatic step_sequencer(input item_t it, output result_t r);
    logic    done;
    error_t  err;
    sample_t value;
    logic    mon;
    done  = 1'b0;
    err   = ERR_NONE;
    value = '0;
    mon   = cfg.monitor_enable;
    if (ph >= PH_SEND_HD && ph <= PH_DIS && frame_cnt != FRAME_MAX) frame_cnt++;
    if (ph == PH_IDLE) begin
      if (it.kind) begin
        cmd_bits = it.channel_select;
        ph       = PH_CSH;
        wait_cnt = '0;
      end
    end else if (wait_cnt < phase_wait(ph)) begin
      wait_cnt++;
    end else begin
      wait_cnt = '0;
      case (ph)
        PH_CSH: begin
          if (mon && !it.dout_level) begin
            err  = ERR_START_LOW;
            done = 1'b1;
          end else begin
            pin_cs   = 1'b0;
            pin_data = 1'b1;
            ph       = PH_SUCS;
          end
        end
        PH_SUCS: begin
          pin_clk   = 1'b1;
          frame_cnt = '0;
          bit_cnt   = '0;
          ph        = PH_SEND_HD;
        end
        PH_SEND_HD: begin
          pin_clk  = 1'b0;
          pin_data = cmd_bits[SEL_W-1];
          cmd_bits = cmd_bits << 1;
          ph       = PH_SEND_SU;
        end
        PH_SEND_SU: begin
          pin_clk = 1'b1;
          bit_cnt++;
          ph = (bit_cnt >= CMD_BITS) ? PH_SMP_HD : PH_SEND_HD;
        end
        PH_SMP_HD: begin
          pin_clk  = 1'b0;
          pin_data = 1'b0;
          ph       = PH_SMP_SU;
        end
        PH_SMP_SU: begin
          pin_clk = 1'b1;
          ph      = PH_SMP_HD2;
        end
        PH_SMP_HD2: begin
          pin_clk = 1'b0;
          ph      = PH_EN;
        end
        PH_EN: begin
          if (mon && it.dout_level) begin
            err  = ERR_NULL_HIGH;
            done = 1'b1;
          end else begin
            pin_clk     = 1'b1;
            bit_cnt     = '0;
            sample_bits = '0;
            ph          = PH_RX_HI;
          end
        end
        PH_RX_HI: begin
          pin_clk = 1'b0;
          ph      = PH_RX_LO;
        end
        PH_RX_LO: begin
          sample_bits = {sample_bits[SAMPLE_W-2:0], it.dout_level};
          bit_cnt++;
          if (bit_cnt < SAMPLE_BITS) begin
            pin_clk = 1'b1;
            ph      = PH_RX_HI;
          end else if (mon) begin
            echo_bits = sample_bits;
            bit_cnt   = '0;
            pin_clk   = 1'b1;
            ph        = PH_EC_HI;
          end else begin
            pin_cs = 1'b1;
            ph     = PH_DIS;
          end
        end
        PH_EC_HI: begin
          pin_clk = 1'b0;
          ph      = PH_EC_LO;
        end
        PH_EC_LO: begin
          echo_bits = echo_bits >> 1;
          if (echo_bits[0] != it.dout_level) begin
            err  = ERR_ECHO;
            done = 1'b1;
          end else begin
            bit_cnt++;
            if (bit_cnt >= ECHO_BITS) begin
              pin_cs = 1'b1;
              ph     = PH_DIS;
            end else begin
              pin_clk = 1'b1;
              ph      = PH_EC_HI;
            end
          end
        end
        PH_DIS: begin
          done = 1'b1;
          if (mon && frame_cnt > cfg.frame_limit_cycles) err = ERR_TIMEOUT;
          else if (mon && !it.dout_level) err = ERR_END_LOW;
          else value = sample_bits;
        end
        default: begin
          ph       = PH_IDLE;
          pin_cs   = 1'b1;
          pin_clk  = 1'b0;
          pin_data = 1'b0;
        end
      endcase
      // A finished or aborted frame puts the pins back to their idle levels.
      if (done) begin
        ph       = PH_IDLE;
        pin_cs   = 1'b1;
        pin_clk  = 1'b0;
        pin_data = 1'b0;
        wait_cnt = '0;
      end
    end
    r.cs_n     = pin_cs;
    r.sclk     = pin_clk;
    r.mosi     = pin_data;
    r.busy_res = (ph != PH_IDLE);
    r.done_res = done;
    r.sample   = value;
    r.error    = err;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_sequencer();
      tick_results_q.delete();
      fail_count = 0;
    end else begin
      if (wr_en) begin
        case (reg_index_t'(wr_index))
          REG_MONITOR_ENABLE: cfg.monitor_enable     = wr_data[0];
          REG_CS_HIGH:        cfg.cs_high_cycles     = wr_data[WAIT_W-1:0];
          REG_CS_SETUP:       cfg.cs_setup_cycles    = wr_data[WAIT_W-1:0];
          REG_DATA_HOLD:      cfg.data_hold_cycles   = wr_data[WAIT_W-1:0];
          REG_DATA_SETUP:     cfg.data_setup_cycles  = wr_data[WAIT_W-1:0];
          REG_CLOCK_HIGH:     cfg.clock_high_cycles  = wr_data[WAIT_W-1:0];
          REG_CLOCK_LOW:      cfg.clock_low_cycles   = wr_data[WAIT_W-1:0];
          REG_FRAME_LIMIT:    cfg.frame_limit_cycles = wr_data[FRAME_W-1:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        in_item.kind           = cmd.kind;
        in_item.channel_select = cmd.channel_select;
        in_item.dout_level     = cmd.dout_level;
        step_sequencer(in_item, want);
        tick_results_q.push_back(want);
      end
      if (res.valid && res.ready) begin
        if (tick_results_q.size() == 0) begin
          $error("result transfer with no tick waiting for it");
          fail_count++;
        end else begin
          want = tick_results_q.pop_front();
          check_field("cs_n", 16'(want.cs_n), 16'(res.cs_n));
          check_field("sclk", 16'(want.sclk), 16'(res.sclk));
          check_field("mosi", 16'(want.mosi), 16'(res.mosi));
          check_field("busy_res", 16'(want.busy_res), 16'(res.busy_res));
          check_field("done_res", 16'(want.done_res), 16'(res.done_res));
          check_field("sample", 16'(want.sample), 16'(res.sample));
          check_field("error", 16'(want.error), 16'(res.error));
        end
      end
    end
    pending    = tick_results_q.size();
    frame_busy = (ph != PH_IDLE);
    tick_phase = ph;
    echo_next  = echo_bits[1];
  end

endmodule

// ===== sim/spi_adc_conversion_master_tb.sv =====
// Testbench top: drives ticks and register writes into the conversion master, gives the verdict.
module spi_adc_conversion_master_tb;
  import sacm_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;

  logic             clk;
  logic             rst;
  logic             wr_en;
  logic [IDX_W-1:0] wr_index;
  logic [CFG_W-1:0] wr_data;

  int unsigned fail_count;
  int unsigned pending;
  logic        frame_busy;
  phase_t      tick_phase;
  logic        echo_next;
  bit          sender_calm = 1'b0;

  sacm_cmd_if cmd_ch();
  sacm_res_if res_ch();

  spi_adc_conversion_master uut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch),
    .res      (res_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  spi_adc_conversion_master_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .fail_count (fail_count),
    .pending    (pending),
    .frame_busy (frame_busy),
    .tick_phase (tick_phase),
    .echo_next  (echo_next)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] data);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = data;
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  // Bits above a register's width carry random junk; the block must drop them.
  task automatic load_config(input cfg_t c);
    logic [3:0] junk;
    junk = 4'($urandom);
    write_reg(REG_MONITOR_ENABLE, {junk, 15'($urandom), c.monitor_enable});
    write_reg(REG_CS_HIGH, {junk, c.cs_high_cycles});
    write_reg(REG_CS_SETUP, {junk, c.cs_setup_cycles});
    write_reg(REG_DATA_HOLD, {junk, c.data_hold_cycles});
    write_reg(REG_DATA_SETUP, {junk, c.data_setup_cycles});
    write_reg(REG_CLOCK_HIGH, {junk, c.clock_high_cycles});
    write_reg(REG_CLOCK_LOW, {junk, c.clock_low_cycles});
    write_reg(REG_FRAME_LIMIT, c.frame_limit_cycles);
    repeat (2) @(negedge clk);
  endtask

  function automatic wait_t short_wait();
    return ($urandom_range(4) == 0) ? wait_t'($urandom_range(9, 3)) : wait_t'($urandom_range(2));
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.monitor_enable    = ($urandom_range(3) != 0);
    c.cs_high_cycles    = short_wait();
    c.cs_setup_cycles   = short_wait();
    c.data_hold_cycles  = short_wait();
    c.data_setup_cycles = short_wait();
    c.clock_high_cycles = short_wait();
    c.clock_low_cycles  = short_wait();
    case ($urandom_range(3))
      0: c.frame_limit_cycles = '0;
      1: c.frame_limit_cycles = FRAME_MAX;
      default: c.frame_limit_cycles = frame_t'($urandom_range(200, 40));
    endcase
    return c;
  endfunction

  // Level on the converter data pin that keeps the current frame well formed,
  // flipped now and then to provoke the monitored errors.
  function automatic logic frame_dout();
    logic lvl;
    case (tick_phase)
      PH_CSH, PH_DIS: lvl = 1'b1;
      PH_EN: lvl = 1'b0;
      PH_EC_LO: lvl = echo_next;
      default: lvl = 1'($urandom);
    endcase
    if ($urandom_range(24) == 0) lvl = ~lvl;
    return lvl;
  endfunction

  task automatic send_tick(input item_t it);
    while (!sender_calm && $urandom_range(99) < 19) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid          = 1'b1;
    cmd_ch.kind           = it.kind;
    cmd_ch.channel_select = it.channel_select;
    cmd_ch.dout_level     = it.dout_level;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends a number of ticks with an optional pause to drain, then ticks until the frame ends.
  task automatic run_frames(input int ticks, input int pause_at);
    item_t it;
    int    n;
    n = 0;
    while (n < ticks || frame_busy) begin
      if (n == pause_at) begin
        cmd_ch.valid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      if (frame_busy) it.kind = ($urandom_range(9) == 0);
      else it.kind = ($urandom_range(3) == 0);
      it.channel_select = sel_t'($urandom);
      it.dout_level     = frame_dout();
      send_tick(it);
      n++;
    end
  endtask

  task automatic settle();
    cmd_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int unsigned cyc;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    cyc = 0;
    forever begin
      // One long hold-off fills the block while the sender keeps offering ticks.
      if (cyc == 600) begin
        res_ch.ready = 1'b0;
        repeat (300) @(negedge clk);
        cyc += 300;
      end
      if (sender_calm) res_ch.ready = 1'b1;
      else res_ch.ready = ($urandom_range(99) >= 19);
      @(negedge clk);
      cyc++;
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("spi_adc_conversion_master verification failed");
    $finish;
  end

  initial begin
    cfg_t c;
    int   p;
    rst                   = 1'b1;
    wr_en                 = 1'b0;
    wr_index              = '0;
    wr_data               = '0;
    cmd_ch.valid          = 1'b0;
    cmd_ch.kind           = 1'b0;
    cmd_ch.channel_select = '0;
    cmd_ch.dout_level     = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: zero waits with monitoring, an aborted start and a start while busy.
    c = '0;
    c.monitor_enable     = 1'b1;
    c.frame_limit_cycles = FRAME_MAX;
    load_config(c);
    send_tick('{kind: 1'b0, channel_select: 4'h0, dout_level: 1'b0});
    send_tick('{kind: 1'b1, channel_select: 4'hF, dout_level: 1'b1});
    send_tick('{kind: 1'b0, channel_select: 4'h0, dout_level: 1'b0});
    send_tick('{kind: 1'b1, channel_select: 4'hA, dout_level: 1'b0});
    send_tick('{kind: 1'b1, channel_select: 4'h5, dout_level: 1'b1});
    run_frames(0, -1);

    for (p = 0; p < 8; p++) begin
      settle();
      c = random_config();
      if (p == 0) c.monitor_enable = 1'b0;
      if (p == 1) begin
        c.monitor_enable     = 1'b1;
        c.frame_limit_cycles = '0;
      end
      if (p == 5) c.frame_limit_cycles = FRAME_MAX;
      load_config(c);
      sender_calm = (p == 3);
      run_frames(24, (p == 2) ? 12 : -1);
    end
    sender_calm = 1'b0;

    // A long chip select high wait, for a single frame.
    settle();
    c = '0;
    c.monitor_enable     = 1'b1;
    c.cs_high_cycles     = wait_t'(64);
    c.frame_limit_cycles = FRAME_MAX;
    load_config(c);
    send_tick('{kind: 1'b1, channel_select: sel_t'($urandom), dout_level: 1'b1});
    run_frames(0, -1);

    cmd_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("spi_adc_conversion_master verification clean");
    end else begin
      $display("spi_adc_conversion_master verification failed");
    end
    $finish;
  end

endmodule
